### sv/ptrm_pkg.sv
// Shared types, constants and arithmetic helpers for the pan/tilt rotation matrix block.
package ptrm_pkg;

    // Field widths and fixed-point formats.
    localparam int ANGLE_W         = 14;
    localparam int ANGLE_FRAC_BITS = 4;
    localparam int OUT_FRAC_BITS   = 14;
    localparam int OUT_W           = 16;
    localparam int IN_TDATA_W      = 32;
    localparam int OUT_TDATA_W     = 9 * OUT_W;

    // Angle reduction.
    localparam int FULL_TURN    = 360 << ANGLE_FRAC_BITS;
    localparam int QUARTER_TURN = 90 << ANGLE_FRAC_BITS;
    localparam int RED_W        = $clog2(FULL_TURN);
    localparam int REM_W        = $clog2(QUARTER_TURN);

    // Binary angle z = floor(rem * 2^30 / QUARTER_TURN), split into an integer
    // multiple and a fractional correction done by a scaled reciprocal.
    localparam int     Z_W     = 32;
    localparam int     Z_MUL   = (1 << 30) / QUARTER_TURN;
    localparam int     Z_REM   = (1 << 30) % QUARTER_TURN;
    localparam int     Z_FIX_S = 24;
    localparam longint Z_FIX_M =
        ((longint'(Z_REM) << Z_FIX_S) + QUARTER_TURN - 1) / QUARTER_TURN;

    // CORDIC datapath.
    localparam int CORDIC_STEPS = 28;
    localparam int XY_W         = 35;
    localparam int XY_FRAC      = 32;
    localparam logic signed [XY_W-1:0] CORDIC_GAIN = XY_W'(64'sd2608131496);

    // Sine/cosine and product formats.
    localparam int TRIG_W = OUT_FRAC_BITS + 2;
    localparam int PROD_W = 2 * TRIG_W;
    localparam logic signed [TRIG_W-1:0] TRIG_ONE = TRIG_W'(1 << OUT_FRAC_BITS);
    localparam logic signed [XY_W-1:0]   XY_ONE   = XY_W'(1 << OUT_FRAC_BITS);
    localparam logic signed [PROD_W-1:0] PROD_ONE = PROD_W'(1 << OUT_FRAC_BITS);

    // Pipeline depths: four angle-preparation stages, the CORDIC steps and one
    // rounding stage per lane, then a product and a rounding stage in the merge.
    localparam int LANE_LAT  = CORDIC_STEPS + 5;
    localparam int MERGE_LAT = 2;
    localparam int PIPE_LAT  = LANE_LAT + MERGE_LAT;

    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } t_quad;

    typedef enum logic {
        ORDER_PAN_TILT = 1'b0,
        ORDER_TILT_PAN = 1'b1
    } t_order;

    typedef struct packed {
        logic [XY_W-1:0] x;
        logic [XY_W-1:0] y;
        logic [Z_W-1:0]  z;
        t_quad           quad;
    } t_cordic;

    typedef struct packed {
        logic [TRIG_W-1:0] cs;
        logic [TRIG_W-1:0] sn;
    } t_trig;

    typedef logic [8:0][OUT_W-1:0] t_mat;

    function automatic logic signed [Z_W-1:0] atan_lut(input int idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            0:       v = Z_W'(536870912);
            1:       v = Z_W'(316933406);
            2:       v = Z_W'(167458907);
            3:       v = Z_W'(85004756);
            4:       v = Z_W'(42667331);
            5:       v = Z_W'(21354465);
            6:       v = Z_W'(10679838);
            7:       v = Z_W'(5340245);
            8:       v = Z_W'(2670163);
            9:       v = Z_W'(1335087);
            10:      v = Z_W'(667544);
            11:      v = Z_W'(333772);
            12:      v = Z_W'(166886);
            13:      v = Z_W'(83443);
            14:      v = Z_W'(41722);
            15:      v = Z_W'(20861);
            16:      v = Z_W'(10430);
            17:      v = Z_W'(5215);
            18:      v = Z_W'(2608);
            19:      v = Z_W'(1304);
            20:      v = Z_W'(652);
            21:      v = Z_W'(326);
            22:      v = Z_W'(163);
            23:      v = Z_W'(81);
            24:      v = Z_W'(41);
            25:      v = Z_W'(20);
            26:      v = Z_W'(10);
            27:      v = Z_W'(5);
            default: v = '0;
        endcase
        return v;
    endfunction

    // Round half up from the CORDIC format to the output format, saturate to +-1.
    function automatic logic signed [TRIG_W-1:0] round_xy(input logic signed [XY_W-1:0] v);
        logic signed [XY_W-1:0] s;
        logic signed [XY_W-1:0] r;
        s = (v + XY_W'(1 << (XY_FRAC - 1 - OUT_FRAC_BITS))) >>> (XY_FRAC - OUT_FRAC_BITS);
        if (s > XY_ONE) begin
            r = XY_ONE;
        end else if (s < -XY_ONE) begin
            r = -XY_ONE;
        end else begin
            r = s;
        end
        return TRIG_W'(r);
    endfunction

    // Round half up a product of two output-format values, saturate to +-1.
    function automatic logic signed [TRIG_W-1:0] round_prod(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] s;
        logic signed [PROD_W-1:0] r;
        s = (p + PROD_W'(1 << (OUT_FRAC_BITS - 1))) >>> OUT_FRAC_BITS;
        if (s > PROD_ONE) begin
            r = PROD_ONE;
        end else if (s < -PROD_ONE) begin
            r = -PROD_ONE;
        end else begin
            r = s;
        end
        return TRIG_W'(r);
    endfunction

endpackage

### sv/pan_tilt_rotation_matrix.sv
// Top level: pan/tilt rotation matrix with two sine/cosine lanes and a merge stage.
// An input transfer passes through 4 angle-preparation stages, 28 CORDIC steps and
// 1 rounding stage per lane, then a product stage and a rounding stage in the merge,
// to its result on the output register. Throughput is one transfer per cycle; the
// whole pipeline stalls only while the output register holds an untaken result.
// Synchronous active-low reset clears the valid pipeline and sets order_mode to 0.
module pan_tilt_rotation_matrix (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Configuration: order_mode in bit 0.
    input  logic                                 i_cfg_we,
    input  logic                                 i_cfg_wdata,
    // Input stream.
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // Fields from bit 0: pan_angle [13:0], tilt_angle [27:14], zero pad [31:28].
    input  logic [ptrm_pkg::IN_TDATA_W-1:0]      i_s_axis_tdata,
    // Output stream.
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    // Fields from bit 0, 16 bits each: m00, m01, m02, m10, m11, m12, m20, m21, m22.
    output logic [ptrm_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata
);
    import ptrm_pkg::*;

    logic                 w_en;
    logic [PIPE_LAT-1:0]  r_vld;
    t_order               r_order_mode;
    t_trig                w_pan;
    t_trig                w_tilt;
    t_mat                 w_mat;

    // Every stage moves together. The pipeline advances whenever the output
    // register is empty or its result is being taken in this cycle, so a new
    // transfer is accepted in the same cycle that a finished result leaves.
    assign w_en            = !r_vld[PIPE_LAT-1] || i_m_axis_tready;
    assign o_s_axis_tready = w_en;
    assign o_m_axis_tvalid = r_vld[PIPE_LAT-1];

    // The valid bits shadow the data pipeline; an accepted transfer enters at
    // the low end and reaches the output register together with its result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[PIPE_LAT-2:0], i_s_axis_tvalid};
        end
    end

    // The user must write the order register only while the block is idle (the block
    // does not enforce this), so the merge stage can read it directly.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order_mode <= ORDER_PAN_TILT;
        end else if (i_cfg_we) begin
            r_order_mode <= t_order'(i_cfg_wdata);
        end
    end

    // Pan lane.
    ptrm_sincos u_pan_lane (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_angle (signed'(i_s_axis_tdata[ANGLE_W-1:0])),
        .o_trig  (w_pan)
    );

    // Tilt lane.
    ptrm_sincos u_tilt_lane (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_angle (signed'(i_s_axis_tdata[2*ANGLE_W-1:ANGLE_W])),
        .o_trig  (w_tilt)
    );

    // Matrix product of the two rotations; its final register is the output register.
    ptrm_merge u_merge (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_order (r_order_mode),
        .i_pan   (w_pan),
        .i_tilt  (w_tilt),
        .o_mat   (w_mat)
    );

    assign o_m_axis_tdata = w_mat;

endmodule

### sv/ptrm_cordic_step.sv
// One registered rotation step of the pipelined CORDIC.
module ptrm_cordic_step #(
    parameter int STEP = 0
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  ptrm_pkg::t_cordic i_stage,
    output ptrm_pkg::t_cordic o_stage
);
    import ptrm_pkg::*;

    localparam logic signed [Z_W-1:0] ATAN = atan_lut(STEP);

    logic signed [XY_W-1:0] w_x;
    logic signed [XY_W-1:0] w_y;
    logic signed [Z_W-1:0]  w_z;
    logic signed [XY_W-1:0] w_dx;
    logic signed [XY_W-1:0] w_dy;
    t_cordic                n_stage;
    t_cordic                r_stage;

    always_comb begin
        w_x  = i_stage.x;
        w_y  = i_stage.y;
        w_z  = i_stage.z;
        w_dx = w_y >>> STEP;
        w_dy = w_x >>> STEP;
        n_stage.quad = i_stage.quad;
        // Rotate toward zero residual angle; a non-negative residual turns forward.
        if (!w_z[Z_W-1]) begin
            n_stage.x = w_x - w_dx;
            n_stage.y = w_y + w_dy;
            n_stage.z = w_z - ATAN;
        end else begin
            n_stage.x = w_x + w_dx;
            n_stage.y = w_y - w_dy;
            n_stage.z = w_z + ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;

endmodule

### sv/ptrm_sincos.sv
// One sine/cosine lane: angle reduction, binary-angle scaling, CORDIC and rounding.
module ptrm_sincos (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic signed [ptrm_pkg::ANGLE_W-1:0]  i_angle,
    output ptrm_pkg::t_trig                      o_trig
);
    import ptrm_pkg::*;

    localparam int EXT_W = ANGLE_W + 1;
    localparam logic signed [EXT_W-1:0] FULL_S   = EXT_W'(FULL_TURN);
    localparam logic signed [EXT_W-1:0] FULL2_S  = EXT_W'(2 * FULL_TURN);
    localparam logic [RED_W-1:0]        Q1_LIM   = RED_W'(QUARTER_TURN);
    localparam logic [RED_W-1:0]        Q2_LIM   = RED_W'(2 * QUARTER_TURN);
    localparam logic [RED_W-1:0]        Q3_LIM   = RED_W'(3 * QUARTER_TURN);

    logic signed [EXT_W-1:0] w_ext;
    logic [RED_W-1:0]        n_red;
    logic [RED_W-1:0]        r_red;
    t_quad                   n_quad;
    logic [RED_W-1:0]        n_base;
    t_quad                   r_quad_a;
    logic [REM_W-1:0]        r_rem;
    t_quad                   r_quad_b;
    logic [Z_W-1:0]          r_zi;
    logic [Z_W-1:0]          r_zf;
    t_quad                   r_quad_c;
    logic signed [Z_W-1:0]   r_z;
    t_cordic                 w_chain [CORDIC_STEPS+1];
    logic signed [TRIG_W-1:0] w_c0;
    logic signed [TRIG_W-1:0] w_s0;
    t_trig                   n_trig;
    t_trig                   r_trig;

    // Fold any 14-bit angle into one full turn.
    always_comb begin
        w_ext = EXT_W'(i_angle);
        if (w_ext >= FULL_S) begin
            n_red = RED_W'(w_ext - FULL_S);
        end else if (w_ext >= 0) begin
            n_red = RED_W'(w_ext);
        end else if (w_ext >= -FULL_S) begin
            n_red = RED_W'(w_ext + FULL_S);
        end else begin
            n_red = RED_W'(w_ext + FULL2_S);
        end
    end

    // Split into a quadrant and a remainder below a quarter turn.
    always_comb begin
        if (r_red < Q1_LIM) begin
            n_quad = QUAD_0;
            n_base = '0;
        end else if (r_red < Q2_LIM) begin
            n_quad = QUAD_1;
            n_base = Q1_LIM;
        end else if (r_red < Q3_LIM) begin
            n_quad = QUAD_2;
            n_base = Q2_LIM;
        end else begin
            n_quad = QUAD_3;
            n_base = Q3_LIM;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_red    <= n_red;
            r_rem    <= REM_W'(r_red - n_base);
            r_quad_a <= n_quad;
            r_zi     <= Z_W'(r_rem) * Z_W'(Z_MUL);
            r_zf     <= Z_W'(r_rem) * Z_W'(Z_FIX_M);
            r_quad_b <= r_quad_a;
            r_z      <= signed'(r_zi + (r_zf >> Z_FIX_S));
            r_quad_c <= r_quad_b;
            r_trig   <= n_trig;
        end
    end

    // The gain is preloaded into x so the vector ends at unit length.
    always_comb begin
        w_chain[0].x    = CORDIC_GAIN;
        w_chain[0].y    = '0;
        w_chain[0].z    = r_z;
        w_chain[0].quad = r_quad_c;
    end

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_step
        ptrm_cordic_step #(
            .STEP (g)
        ) u_step (
            .i_clk   (i_clk),
            .i_en    (i_en),
            .i_stage (w_chain[g]),
            .o_stage (w_chain[g+1])
        );
    end

    // Round, then map the first-quadrant result onto the real quadrant.
    always_comb begin
        w_c0 = round_xy(signed'(w_chain[CORDIC_STEPS].x));
        w_s0 = round_xy(signed'(w_chain[CORDIC_STEPS].y));
        case (w_chain[CORDIC_STEPS].quad)
            QUAD_0: begin
                n_trig.cs = w_c0;
                n_trig.sn = w_s0;
            end
            QUAD_1: begin
                n_trig.cs = -w_s0;
                n_trig.sn = w_c0;
            end
            QUAD_2: begin
                n_trig.cs = -w_c0;
                n_trig.sn = -w_s0;
            end
            default: begin
                n_trig.cs = w_s0;
                n_trig.sn = -w_c0;
            end
        endcase
    end

    assign o_trig = r_trig;

endmodule

### sv/ptrm_merge.sv
// Merge stage: combines the pan and tilt lanes into the nine matrix entries.
module ptrm_merge (
    input  logic             i_clk,
    input  logic             i_en,
    input  ptrm_pkg::t_order i_order,
    input  ptrm_pkg::t_trig  i_pan,
    input  ptrm_pkg::t_trig  i_tilt,
    output ptrm_pkg::t_mat   o_mat
);
    import ptrm_pkg::*;

    logic signed [PROD_W-1:0] r_pc_tc;
    logic signed [PROD_W-1:0] r_pc_ts;
    logic signed [PROD_W-1:0] r_ps_tc;
    logic signed [PROD_W-1:0] r_ps_ts;
    logic signed [TRIG_W-1:0] r_pc;
    logic signed [TRIG_W-1:0] r_ps;
    logic signed [TRIG_W-1:0] r_tc;
    logic signed [TRIG_W-1:0] r_ts;
    logic signed [TRIG_W-1:0] w_cc;
    logic signed [TRIG_W-1:0] w_cs_p;
    logic signed [TRIG_W-1:0] w_cs_n;
    logic signed [TRIG_W-1:0] w_sc_p;
    logic signed [TRIG_W-1:0] w_sc_n;
    logic signed [TRIG_W-1:0] w_ss_n;
    logic signed [TRIG_W-1:0] w_m [9];
    t_mat                     n_mat;
    t_mat                     r_mat;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pc_tc <= signed'(i_pan.cs) * signed'(i_tilt.cs);
            r_pc_ts <= signed'(i_pan.cs) * signed'(i_tilt.sn);
            r_ps_tc <= signed'(i_pan.sn) * signed'(i_tilt.cs);
            r_ps_ts <= signed'(i_pan.sn) * signed'(i_tilt.sn);
            r_pc    <= i_pan.cs;
            r_ps    <= i_pan.sn;
            r_tc    <= i_tilt.cs;
            r_ts    <= i_tilt.sn;
            r_mat   <= n_mat;
        end
    end

    // A negated product rounds differently from a negated rounded product,
    // so each sign that is needed gets its own rounding.
    always_comb begin
        w_cc   = round_prod(r_pc_tc);
        w_cs_p = round_prod(r_pc_ts);
        w_cs_n = round_prod(-r_pc_ts);
        w_sc_p = round_prod(r_ps_tc);
        w_sc_n = round_prod(-r_ps_tc);
        w_ss_n = round_prod(-r_ps_ts);
        case (i_order)
            ORDER_TILT_PAN: begin
                w_m[0] = w_cc;
                w_m[1] = w_sc_n;
                w_m[2] = -r_ts;
                w_m[3] = r_ps;
                w_m[4] = r_pc;
                w_m[5] = '0;
                w_m[6] = w_cs_p;
                w_m[7] = w_ss_n;
                w_m[8] = r_tc;
            end
            default: begin
                w_m[0] = w_cc;
                w_m[1] = -r_ps;
                w_m[2] = w_cs_n;
                w_m[3] = w_sc_p;
                w_m[4] = r_pc;
                w_m[5] = w_ss_n;
                w_m[6] = r_ts;
                w_m[7] = '0;
                w_m[8] = r_tc;
            end
        endcase
        for (int k = 0; k < 9; k++) begin
            n_mat[k] = OUT_W'(w_m[k]);
        end
    end

    assign o_mat = r_mat;

endmodule
